@@ rtl/dcd_pkg.sv @@
// Shared types, constants and keyword tables for the delimited command deframer.
// No dependencies; imported by dcd_engine and delimited_command_deframer.
package dcd_pkg;

  // Largest frame buffer; a frame holds at most FRAME_BYTES-1 stored bytes.
  localparam int FRAME_BYTES = 64;
  localparam int CNT_W       = $clog2(FRAME_BYTES);

  localparam int TICK_W = 16;
  localparam int LEN_W  = 6;
  localparam int CLS_W  = 2;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd300;
  localparam logic [TICK_W-1:0] TICK_MAX      = '1;

  localparam logic [7:0] OPEN_MARK  = 8'h3C;  // '<'
  localparam logic [7:0] CLOSE_MARK = 8'h3E;  // '>'
  localparam logic [7:0] NUL_BYTE   = 8'h00;

  localparam int PING_LEN = 4;
  localparam int REQ_LEN  = 10;
  localparam int INFO_LEN = 10;

  // Request kind carried on tuser.
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Bit positions in the keyword alive mask.
  localparam int KW_PING = 0;
  localparam int KW_REQ  = 1;
  localparam int KW_INFO = 2;

  typedef enum logic [CLS_W-1:0] {
    CLS_PING    = 2'd0,
    CLS_REQ_CFG = 2'd1,
    CLS_INFO    = 2'd2,
    CLS_UNKNOWN = 2'd3
  } dcd_class_t;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } dcd_item_t;

  typedef struct packed {
    logic             valid;
    dcd_class_t       command_class;
    logic [LEN_W-1:0] frame_length;
  } dcd_result_t;

  function automatic logic [7:0] ping_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h50;  // P
      2'd1:    c = 8'h49;  // I
      2'd2:    c = 8'h4E;  // N
      2'd3:    c = 8'h47;  // G
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] req_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h52;  // R
      4'd1:    c = 8'h45;  // E
      4'd2:    c = 8'h51;  // Q
      4'd3:    c = 8'h5F;  // _
      4'd4:    c = 8'h43;  // C
      4'd5:    c = 8'h4F;  // O
      4'd6:    c = 8'h4E;  // N
      4'd7:    c = 8'h46;  // F
      4'd8:    c = 8'h49;  // I
      4'd9:    c = 8'h47;  // G
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] info_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h49;  // I
      4'd1:    c = 8'h4E;  // N
      4'd2:    c = 8'h46;  // F
      4'd3:    c = 8'h4F;  // O
      4'd4:    c = 8'h5F;  // _
      4'd5:    c = 8'h46;  // F
      4'd6:    c = 8'h49;  // I
      4'd7:    c = 8'h53;  // S
      4'd8:    c = 8'h49;  // I
      4'd9:    c = 8'h4F;  // O
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/delimited_command_deframer.sv @@
// Top level of the delimited command deframer: stream ports, input and result registers.
// Depends on dcd_pkg and dcd_engine.

// The block takes one request per clock: a received UART byte (in_tuser 0) or a
// one millisecond tick (in_tuser 1). A '<' opens or restarts a frame, bytes outside
// a frame are ignored, and a '>' closes the frame and emits one result with the
// command class (0 ping, 1 config request, 2 info prefix, 3 unknown) in
// out_tdata[1:0] and the stored byte count in out_tdata[7:2]. A zero byte ends
// the text used for matching but still counts. A frame is dropped without result
// when it already holds 63 bytes and another data byte arrives, or when the ticks
// since the last byte exceed the timeout register (write cfg_wdata with cfg_we,
// only while idle; reset value 300). Throughput is one request per cycle while the
// result register is free or being drained; a result is offered once its '>' has
// passed the input register and the frame engine between the two registers has
// loaded the result register. The result register holds while out_tready is low,
// and the input side keeps accepting as long as the result register is free or
// is being drained in the same cycle.
module delimited_command_deframer
  import dcd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // Input request channel
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] rx_byte
  input  logic              in_tuser,   // [0] func
  // Result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [1:0] command_class, [7:2] frame_length
  // Configuration
  input  logic              cfg_we,
  input  logic [TICK_W-1:0] cfg_wdata
);

  logic              in_valid_r;
  dcd_item_t         in_item_r;
  logic              out_valid_r;
  logic [7:0]        out_data_r;
  logic [TICK_W-1:0] timeout_r;

  logic              advance;
  dcd_result_t       result;

  // Process the held request when the result register can take whatever it yields.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  dcd_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (advance),
    .item        (in_item_r),
    .timeout_lim (timeout_r),
    .result      (result)
  );

  // Input register: load on accept, drop the valid once processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.func    <= in_tuser;
      in_item_r.rx_byte <= in_tdata;
    end
  end

  // Result register: load a closed frame, hold until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && result.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      out_data_r <= {result.frame_length, result.command_class};
    end
  end

  // Timeout register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ rtl/dcd_engine.sv @@
// Frame state and keyword matcher: consumes one registered request per enable.
// Depends on dcd_pkg.
module dcd_engine
  import dcd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  dcd_item_t         item,
  input  logic [TICK_W-1:0] timeout_lim,
  output dcd_result_t       result
);

  logic              in_frame_r, in_frame_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [TICK_W-1:0] ticks_r, ticks_nxt;
  logic [2:0]        alive_r, alive_nxt;
  logic              ended_r, ended_nxt;

  logic [7:0]        b;
  logic              ping_ok, req_ok, info_ok;
  logic [2:0]        cls_alive;
  logic [CNT_W+LEN_W-1:0] len_ext;

  assign b = item.rx_byte;

  // Per-keyword check of the byte at the current stored position.
  always_comb begin
    if (b == NUL_BYTE) begin
      ping_ok = (count_r == CNT_W'(PING_LEN));
      req_ok  = (count_r == CNT_W'(REQ_LEN));
      info_ok = (count_r >= CNT_W'(INFO_LEN));
    end else begin
      ping_ok = (count_r < CNT_W'(PING_LEN)) && (b == ping_char(count_r[1:0]));
      req_ok  = (count_r < CNT_W'(REQ_LEN))  && (b == req_char(count_r[3:0]));
      info_ok = (count_r >= CNT_W'(INFO_LEN)) || (b == info_char(count_r[3:0]));
    end
  end

  // Classify the open frame as it would close now; lowest code wins.
  always_comb begin
    cls_alive = alive_r;
    if (!ended_r) begin
      if (count_r != CNT_W'(PING_LEN)) cls_alive[KW_PING] = 1'b0;
      if (count_r != CNT_W'(REQ_LEN))  cls_alive[KW_REQ]  = 1'b0;
      if (count_r <  CNT_W'(INFO_LEN)) cls_alive[KW_INFO] = 1'b0;
    end
  end

  assign len_ext = {{LEN_W{1'b0}}, count_r};

  always_comb begin
    in_frame_nxt         = in_frame_r;
    count_nxt            = count_r;
    ticks_nxt            = ticks_r;
    alive_nxt            = alive_r;
    ended_nxt            = ended_r;
    result.valid         = 1'b0;
    result.frame_length  = len_ext[LEN_W-1:0];
    if (cls_alive[KW_PING])      result.command_class = CLS_PING;
    else if (cls_alive[KW_REQ])  result.command_class = CLS_REQ_CFG;
    else if (cls_alive[KW_INFO]) result.command_class = CLS_INFO;
    else                         result.command_class = CLS_UNKNOWN;

    if (en) begin
      if (item.func == FUNC_TICK) begin
        if (ticks_r != TICK_MAX) ticks_nxt = ticks_r + TICK_W'(1);
        if (in_frame_r && (ticks_nxt > timeout_lim)) begin
          in_frame_nxt = 1'b0;
          count_nxt    = '0;
          alive_nxt    = '1;
          ended_nxt    = 1'b0;
        end
      end else begin
        ticks_nxt = '0;
        if (b == OPEN_MARK) begin
          in_frame_nxt = 1'b1;
          count_nxt    = '0;
          alive_nxt    = '1;
          ended_nxt    = 1'b0;
        end else if (in_frame_r) begin
          if (b == CLOSE_MARK || count_r == CNT_W'(FRAME_BYTES-1)) begin
            // Close emits a result; an overfull frame is dropped silently.
            result.valid = (b == CLOSE_MARK);
            in_frame_nxt = 1'b0;
            count_nxt    = '0;
            alive_nxt    = '1;
            ended_nxt    = 1'b0;
          end else begin
            count_nxt = count_r + CNT_W'(1);
            if (!ended_r) begin
              alive_nxt = alive_r & {info_ok, req_ok, ping_ok};
              ended_nxt = (b == NUL_BYTE);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      count_r    <= '0;
      ticks_r    <= '0;
      alive_r    <= '1;
      ended_r    <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
      count_r    <= count_nxt;
      ticks_r    <= ticks_nxt;
      alive_r    <= alive_nxt;
      ended_r    <= ended_nxt;
    end
  end

endmodule
